FILE: rtl/cdfir_pkg.sv
`timescale 1ns / 1ps

package cdfir_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 40;
  localparam int TAP_INDEX_W = 6;
  localparam int TAP_COUNT_W = 7;
  localparam int DEC_W       = 9;
  localparam int PHASE_W     = 8;
  localparam int LINE_W      = 2 * SAMPLE_W;

  // Stream and configuration port widths
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 2 * ACC_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  // Slave tdata layout, lowest bit first
  localparam int SAMPLE_I_LSB  = 0;
  localparam int SAMPLE_Q_LSB  = SAMPLE_I_LSB + SAMPLE_W;
  localparam int TAP_INDEX_LSB = SAMPLE_Q_LSB + SAMPLE_W;
  localparam int TAP_VALUE_LSB = TAP_INDEX_LSB + TAP_INDEX_W;

  // Request kinds carried in tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TAP    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION = 2'd1;

  // Register reset values and limits
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;
  localparam logic [DEC_W-1:0]       DEC_RESET       = 9'd1;
  localparam logic [DEC_W-1:0]       DEC_MAX         = 9'd256;

  // Per-cycle control from the sequencer to the MAC unit
  typedef struct packed {
    logic start;  // clear the accumulators
    logic valid;  // an operand pair is being read this cycle
    logic last;   // final operand pair of this output
  } mac_ctl_t;

endpackage

FILE: rtl/complex_decimating_fir.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                      | Word
// ----------+-----------+--------------------------------+----------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | tuser: req_type; tdata: sample/tap
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata: out_i, out_q
// cfg       | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// A tap write and a sample that yields no output leave the filter idle.
// A sample that yields an output keeps s_axis_tready low for a whole filter pass
// (nt = taps in use): one shared two-lane MAC reads nt sample/coefficient pairs,
// one per cycle, from the memories, then the read, product and accumulate
// stages drain, and ST_PUSH moves the sum into the output register.
// Reset (rst, synchronous) clears the counters, the registers to 64 taps and
// decimation 1, and the valid bits of both memories, so they read as zeros.
// The output register holds a word until taken; a new input word is accepted
// meanwhile, and a finished sum waits in the accumulators while the register is full.
// cfg_ready is always high; write it only while the filter is idle.

module complex_decimating_fir #(
  parameter int MAX_TAPS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] sample_i, [31:16] sample_q, [37:32] tap_index, [53:38] tap_value, [55:54] zero
  input  logic [cdfir_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [0] req_type
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [39:0] out_i, [79:40] out_q
  output logic [cdfir_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cdfir_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cdfir_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cdfir_pkg::*;

  // Memory address width; both memories are a power of two deep so the
  // delay line pointer wraps by itself.
  localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  // Counter width able to hold MAX_TAPS itself
  localparam int CW  = $clog2(MAX_TAPS + 1);
  localparam int NTW = (CW > TAP_COUNT_W) ? CW : TAP_COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_PUSH
  } state_t;

  state_t state;

  // Configuration registers
  logic [TAP_COUNT_W-1:0] tap_count;
  logic [DEC_W-1:0]       decimation;

  // Filter state
  logic [CW-1:0]      fill;
  logic [PHASE_W-1:0] phase;
  logic [AW-1:0]      wp;       // address of the newest sample
  logic [AW-1:0]      line_ptr; // read address walking oldest to newest
  logic [CW-1:0]      k;        // tap being read

  // Output register
  logic                    out_vld;
  logic signed [ACC_W-1:0] out_i, out_q;

  // Input word fields
  logic                   req_type;
  logic [SAMPLE_W-1:0]    sample_i, sample_q;
  logic [TAP_INDEX_W-1:0] tap_index;
  logic [COEF_W-1:0]      tap_value;

  assign req_type  = s_axis_tuser[0];
  assign sample_i  = s_axis_tdata[SAMPLE_I_LSB +: SAMPLE_W];
  assign sample_q  = s_axis_tdata[SAMPLE_Q_LSB +: SAMPLE_W];
  assign tap_index = s_axis_tdata[TAP_INDEX_LSB +: TAP_INDEX_W];
  assign tap_value = s_axis_tdata[TAP_VALUE_LSB +: COEF_W];

  // Effective tap count and decimation after clamping
  logic [NTW-1:0]   tc_ext;
  logic [CW-1:0]    nt;
  logic [DEC_W-1:0] dec_eff;

  always_comb begin
    tc_ext = NTW'(tap_count);
    if (tc_ext == '0) begin
      nt = CW'(1);
    end else if (tc_ext > NTW'(MAX_TAPS)) begin
      nt = CW'(MAX_TAPS);
    end else begin
      nt = CW'(tc_ext);
    end
    if (decimation == '0) begin
      dec_eff = DEC_W'(1);
    end else if (decimation > DEC_MAX) begin
      dec_eff = DEC_MAX;
    end else begin
      dec_eff = decimation;
    end
  end

  // Handshakes
  logic s_take, sample_take, tap_take, cfg_take;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign s_take        = s_axis_tvalid && s_axis_tready;
  assign sample_take   = s_take && (req_type == REQ_SAMPLE);
  // Drop tap writes beyond the coefficient store
  assign tap_take      = s_take && (req_type == REQ_TAP) && (int'(tap_index) < MAX_TAPS);
  assign cfg_take      = cfg_valid && cfg_ready;

  // Fill and decimation phase: does this sample complete an output?
  logic [CW-1:0]      fill_inc, fill_next;
  logic [DEC_W-1:0]   phase_inc;
  logic [PHASE_W-1:0] phase_next;
  logic               emit;
  logic [AW-1:0]      wa, start_ptr;
  logic               last_tap;

  always_comb begin
    fill_inc  = fill + 1'b1;
    phase_inc = {1'b0, phase} + 1'b1;
    fill_next = fill;
    phase_next = phase;
    emit      = 1'b0;
    if (fill < nt) begin
      fill_next = fill_inc;
      if (fill_inc == nt) begin
        emit       = 1'b1;
        phase_next = '0;
      end
    end else if (phase_inc >= dec_eff) begin
      emit       = 1'b1;
      phase_next = '0;
    end else begin
      phase_next = phase_inc[PHASE_W-1:0];
    end
  end

  // New sample goes one slot past the newest; the window starts nt-1 back
  assign wa        = wp + 1'b1;
  assign start_ptr = wa - AW'(nt) + 1'b1;
  assign last_tap  = (k == nt - 1'b1);

  // Shared two-lane multiply-accumulate
  mac_ctl_t                mac_ctl;
  logic                    mac_done;
  logic signed [ACC_W-1:0] acc_i, acc_q;

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tap_count  <= TAP_COUNT_RESET;
      decimation <= DEC_RESET;
      fill       <= '0;
      phase      <= '0;
      wp         <= '0;
      out_vld    <= 1'b0;
    end else begin
      if (cfg_take) begin
        case (cfg_index)
          REG_TAP_COUNT:  tap_count  <= cfg_data[TAP_COUNT_W-1:0];
          REG_DECIMATION: decimation <= cfg_data[DEC_W-1:0];
          default: ;
        endcase
      end

      // Drop the taken word; ST_PUSH refills the register on its own
      if (out_vld && m_axis_tready && (state != ST_PUSH)) begin
        out_vld <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample_take) begin
            wp    <= wa;
            fill  <= fill_next;
            phase <= phase_next;
            if (emit) begin
              line_ptr <= start_ptr;
              k        <= '0;
              state    <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          // Advance one tap per cycle
          line_ptr <= line_ptr + 1'b1;
          k        <= k + 1'b1;
          if (last_tap) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (mac_done) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          // Hold the sum in the accumulators until the output register frees
          if (!out_vld || m_axis_tready) begin
            out_vld <= 1'b1;
            out_i   <= acc_i;
            out_q   <= acc_q;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sample line and coefficient memories
  logic [LINE_W-1:0] rd_line_data;
  logic [COEF_W-1:0] rd_coef_data;
  logic              rd_en;

  assign rd_en = (state == ST_RUN);

  cdfir_store #(
    .AW (AW)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .line_wr_en   (sample_take),
    .line_wr_addr (wa),
    .line_wr_data ({sample_q, sample_i}),
    .coef_wr_en   (tap_take),
    .coef_wr_addr (AW'(tap_index)),
    .coef_wr_data (tap_value),
    .rd_en        (rd_en),
    .rd_line_addr (line_ptr),
    .rd_coef_addr (AW'(k)),
    .rd_line_data (rd_line_data),
    .rd_coef_data (rd_coef_data)
  );

  always_comb begin
    mac_ctl.start = sample_take && emit;
    mac_ctl.valid = rd_en;
    mac_ctl.last  = rd_en && last_tap;
  end

  cdfir_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .line_data (rd_line_data),
    .coef_data (rd_coef_data),
    .done      (mac_done),
    .acc_i     (acc_i),
    .acc_q     (acc_q)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {out_q, out_i};

endmodule

FILE: rtl/cdfir_store.sv
`timescale 1ns / 1ps

module cdfir_store #(
  parameter int AW = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          line_wr_en,
  input  logic [AW-1:0]                 line_wr_addr,
  input  logic [cdfir_pkg::LINE_W-1:0]  line_wr_data,
  input  logic                          coef_wr_en,
  input  logic [AW-1:0]                 coef_wr_addr,
  input  logic [cdfir_pkg::COEF_W-1:0]  coef_wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_line_addr,
  input  logic [AW-1:0]                 rd_coef_addr,
  output logic [cdfir_pkg::LINE_W-1:0]  rd_line_data,
  output logic [cdfir_pkg::COEF_W-1:0]  rd_coef_data
);
  import cdfir_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [LINE_W-1:0] line_mem [DEPTH];
  logic [COEF_W-1:0] coef_mem [DEPTH];
  logic [DEPTH-1:0]  line_vld;
  logic [DEPTH-1:0]  coef_vld;

  logic [LINE_W-1:0] line_raw;
  logic [COEF_W-1:0] coef_raw;
  logic              line_raw_vld;
  logic              coef_raw_vld;

  // Entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      line_vld <= '0;
      coef_vld <= '0;
    end else begin
      if (line_wr_en) line_vld[line_wr_addr] <= 1'b1;
      if (coef_wr_en) coef_vld[coef_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (line_wr_en) line_mem[line_wr_addr] <= line_wr_data;
    if (coef_wr_en) coef_mem[coef_wr_addr] <= coef_wr_data;
    if (rd_en) begin
      line_raw     <= line_mem[rd_line_addr];
      coef_raw     <= coef_mem[rd_coef_addr];
      line_raw_vld <= line_vld[rd_line_addr];
      coef_raw_vld <= coef_vld[rd_coef_addr];
    end
  end

  assign rd_line_data = line_raw_vld ? line_raw : '0;
  assign rd_coef_data = coef_raw_vld ? coef_raw : '0;

endmodule

FILE: rtl/cdfir_mac.sv
`timescale 1ns / 1ps

module cdfir_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  cdfir_pkg::mac_ctl_t                 ctl,
  input  logic        [cdfir_pkg::LINE_W-1:0] line_data,
  input  logic        [cdfir_pkg::COEF_W-1:0] coef_data,
  output logic                                done,
  output logic signed [cdfir_pkg::ACC_W-1:0]  acc_i,
  output logic signed [cdfir_pkg::ACC_W-1:0]  acc_q
);
  import cdfir_pkg::*;

  logic                     rd_vld, rd_last;
  logic                     prod_vld, prod_last;
  logic signed [PROD_W-1:0] prod_i, prod_q;
  logic signed [SAMPLE_W-1:0] x_i, x_q;
  logic signed [COEF_W-1:0]   c;

  assign x_i = line_data[SAMPLE_W-1:0];
  assign x_q = line_data[LINE_W-1:SAMPLE_W];
  assign c   = coef_data;

  // Control: align with the registered read, then follow the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      prod_vld  <= 1'b0;
      prod_last <= 1'b0;
      done      <= 1'b0;
    end else begin
      rd_vld    <= ctl.valid;
      rd_last   <= ctl.valid && ctl.last;
      prod_vld  <= rd_vld;
      prod_last <= rd_last;
      done      <= prod_vld && prod_last;
    end
  end

  always_ff @(posedge clk) begin
    prod_i <= x_i * c;
    prod_q <= x_q * c;
    if (ctl.start) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (prod_vld) begin
      acc_i <= acc_i + ACC_W'(prod_i);
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

endmodule

FILE: rtl/cdfir_checker.sv
`timescale 1ns / 1ps

module cdfir_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [0:0]                      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cdfir_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import cdfir_pkg::*;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed or dropped while stalled");

  // Reset leaves no output word pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A tap write never makes the filter busy
  a_tap_write_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_TAP) |=> s_axis_tready)
    else $error("tap write stalled the input");

  // A new output word only appears as a filter pass finishes
  a_out_from_pass: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready && !$past(s_axis_tready))
    else $error("output word without a completed filter pass");

endmodule

bind complex_decimating_fir cdfir_checker u_cdfir_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
